/* rtl/cdm_pkg.sv */
// Package for the clock display multiplexer.
// Holds the request/response payload types, action and register codes,
// and the seven-segment font. No dependencies.
`timescale 1ns / 1ps

package cdm_pkg;

   localparam int unsigned SegWidth   = 8;
   localparam int unsigned TimeWidth  = 7;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned PosWidth   = 2;
   localparam int unsigned CsrIdxWidth  = 1;
   localparam int unsigned CsrDataWidth = 1;

   localparam logic [TimeWidth-1:0] TimeMax   = 7'd99;
   localparam logic [SegWidth-1:0]  HoursMark = 8'h54;
   localparam logic [SegWidth-1:0]  MinsMark  = 8'h23;
   localparam logic [SegWidth-1:0]  DotBit    = 8'h80;
   localparam logic [SegWidth-1:0]  BlankSeg  = 8'h00;

   // scan positions
   localparam logic [PosWidth-1:0] PosFirst = 2'd0;
   localparam logic [PosWidth-1:0] PosMark  = 2'd2;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_FLIP = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_VIEW_SELECT = 1'b0,
      CSR_SHOW_DIGITS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]           action;
      logic [TimeWidth-1:0] hours;
      logic [TimeWidth-1:0] minutes;
   } req_type;

   typedef struct packed {
      logic [SegWidth-1:0] segment_drive;
      logic [PosWidth-1:0] digit_index;
      logic                digit_lit;
   } rsp_type;

   function automatic logic [SegWidth-1:0] seg_font(input logic [DigitWidth-1:0] digit);
      logic [SegWidth-1:0] seg;
      case (digit)
         4'd0:    seg = 8'h3f;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5b;
         4'd3:    seg = 8'h4f;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6d;
         4'd6:    seg = 8'h7d;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7f;
         4'd9:    seg = 8'h6f;
         default: seg = BlankSeg;
      endcase
      return seg;
   endfunction

endpackage

/* rtl/clock_display_multiplexer_core.sv */
// Top level of the clock display multiplexer: request register, response
// register, control registers and handshakes. Uses cdm_pkg and cdm_store.
`timescale 1ns / 1ps
//
//  Channel   Ports                              Direction  Payload
//  request   req_valid / req_ready / req_data   in         action, hours, minutes
//  response  rsp_valid / rsp_ready / rsp_data   out        segment_drive, digit_index,
//                                                          digit_lit
//  csr       csr_write_en / csr_index / csr_wdata  in      view select, show digits
//
//  An accepted request is held in the request register, then passes through
//  the buffer update into the response register, which raises rsp_valid.
//  One request per cycle is sustained while rsp_ready is high.
//  Reset (synchronous) blanks all digit buffers, sets scan position to 2 and
//  clears both control registers.
//  A stalled response holds the pipe; req_ready drops only when both the
//  request and response registers are full and rsp_ready is low.

module clock_display_multiplexer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cdm_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cdm_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_en,
   input  logic [cdm_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [cdm_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import cdm_pkg::*;

   // control registers
   logic    mode_ff, mode_in;
   logic    show_ff, show_in;

   // request stage
   req_type req_ff;
   logic    req_vld_ff, req_vld_in;

   // response stage
   rsp_type rsp_ff, rsp_in;
   logic    rsp_vld_ff, rsp_vld_in;

   logic    advance;   // response register can take a new value
   logic    step;      // request stage is applied to state this cycle
   logic    req_take;

   assign advance  = !rsp_vld_ff || rsp_ready;
   assign step     = req_vld_ff && advance;
   assign req_ready = !req_vld_ff || advance;
   assign req_take = req_valid && req_ready;

   always_comb begin
      mode_in = mode_ff;
      show_in = show_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_VIEW_SELECT: mode_in = csr_wdata[0];
            CSR_SHOW_DIGITS: show_in = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (req_take) begin
         req_vld_in = 1'b1;
      end else if (advance) begin
         req_vld_in = 1'b0;
      end else begin
         req_vld_in = req_vld_ff;
      end

      if (step) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   // state update and response forming
   cdm_store u_store (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .req          (req_ff),
      .view_select  (mode_ff),
      .show_digits  (show_ff),
      .rsp_in       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         show_ff    <= 1'b0;
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         show_ff    <= show_in;
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // scan position never reaches 3
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_ff.digit_index != 2'd3)
      else $error("digit_index out of range");

   // indicator digit carries the mode mark
   a_mark_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.digit_index == PosMark) |->
      ((rsp_ff.segment_drive == HoursMark && !mode_ff) ||
       (rsp_ff.segment_drive == MinsMark && mode_ff)))
      else $error("indicator digit mismatch");

   // lit flag follows the show register
   a_lit_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_ff.digit_lit == show_ff)
      else $error("digit_lit mismatch");

   // a full request stage under a stalled response holds off new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && rsp_vld_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while pipe is full");

endmodule

/* rtl/cdm_font.sv */
// Two-digit font encoder: saturates a time value to 99, splits it into
// tens and units, and maps both to segment patterns. Uses cdm_pkg.
`timescale 1ns / 1ps

module cdm_font (
   input  logic [cdm_pkg::TimeWidth-1:0] raw,
   output logic [cdm_pkg::SegWidth-1:0]  tens_seg,
   output logic [cdm_pkg::SegWidth-1:0]  units_seg
);
   import cdm_pkg::*;

   logic [TimeWidth-1:0]  sat;
   logic [14:0]           prod;
   logic [DigitWidth-1:0] tens;
   logic [TimeWidth-1:0]  tens_x10;
   logic [DigitWidth-1:0] units;

   always_comb begin
      sat = (raw > TimeMax) ? TimeMax : raw;
      // v/10 == (v*205)>>11 for v <= 99
      prod = 15'(sat) * 15'd205;
      tens = prod[14:11];
      tens_x10 = TimeWidth'({tens, 3'b000}) + TimeWidth'({tens, 1'b0});
      units = DigitWidth'(sat - tens_x10);
      tens_seg  = seg_font(tens);
      units_seg = seg_font(units);
   end

endmodule

/* rtl/cdm_store.sv */
// Digit buffers and scan position: applies one request to the state and
// forms its response from the updated state. Uses cdm_pkg and cdm_font.
`timescale 1ns / 1ps

module cdm_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  cdm_pkg::req_type req,
   input  logic             view_select,
   input  logic             show_digits,
   output cdm_pkg::rsp_type rsp_in
);
   import cdm_pkg::*;

   logic [SegWidth-1:0] hr_tens_ff, hr_units_ff, mn_tens_ff, mn_units_ff;
   logic [SegWidth-1:0] hr_tens_in, hr_units_in, mn_tens_in, mn_units_in;
   logic [PosWidth-1:0] scan_ff, scan_in;
   logic [SegWidth-1:0] hr_tens_font, hr_units_font, mn_tens_font, mn_units_font;
   logic [SegWidth-1:0] seg;

   cdm_font u_hr_font (.raw(req.hours),   .tens_seg(hr_tens_font), .units_seg(hr_units_font));
   cdm_font u_mn_font (.raw(req.minutes), .tens_seg(mn_tens_font), .units_seg(mn_units_font));

   always_comb begin
      hr_tens_in  = hr_tens_ff;
      hr_units_in = hr_units_ff;
      mn_tens_in  = mn_tens_ff;
      mn_units_in = mn_units_ff;
      scan_in     = scan_ff;
      case (action_type'(req.action))
         ACT_LOAD: begin
            hr_tens_in  = hr_tens_font;
            hr_units_in = hr_units_font;
            mn_tens_in  = mn_tens_font;
            mn_units_in = mn_units_font;
         end
         ACT_FLIP: begin
            if (view_select) begin
               mn_tens_in = mn_tens_ff ^ DotBit;
            end else begin
               hr_tens_in = hr_tens_ff ^ DotBit;
            end
         end
         ACT_TICK: begin
            scan_in = (scan_ff >= PosMark) ? PosFirst : scan_ff + 2'd1;
         end
         default: begin
         end
      endcase

      if (scan_in >= PosMark) begin
         seg = view_select ? MinsMark : HoursMark;
      end else begin
         case ({view_select, scan_in[0]})
            2'b00:   seg = hr_tens_in;
            2'b01:   seg = hr_units_in;
            2'b10:   seg = mn_tens_in;
            default: seg = mn_units_in;
         endcase
      end

      rsp_in.segment_drive = seg;
      rsp_in.digit_index   = scan_in;
      rsp_in.digit_lit     = show_digits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hr_tens_ff  <= BlankSeg;
         hr_units_ff <= BlankSeg;
         mn_tens_ff  <= BlankSeg;
         mn_units_ff <= BlankSeg;
         scan_ff     <= PosMark;
      end else if (step) begin
         hr_tens_ff  <= hr_tens_in;
         hr_units_ff <= hr_units_in;
         mn_tens_ff  <= mn_tens_in;
         mn_units_ff <= mn_units_in;
         scan_ff     <= scan_in;
      end
   end

endmodule
